[hw/rtl/arpr_pkg.sv]
// arpr_pkg: shared types and constants for the arp request responder
// no dependencies; imported by arpr_parse and arp_request_responder
package arpr_pkg;

  localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
  localparam logic [15:0] HTYPE_ETH     = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  HLEN_MAC      = 8'd6;
  localparam logic [7:0]  PLEN_IPV4     = 8'd4;
  localparam logic [15:0] OP_REQUEST    = 16'h0001;
  localparam logic [15:0] OP_REPLY      = 16'h0002;

  localparam int          MIN_FRAME_LEN = 42;
  localparam logic [5:0]  MIN_LAST_POS  = 6'(MIN_FRAME_LEN - 1);
  localparam logic [5:0]  POS_MAX       = 6'd63;

  localparam logic [31:0] OWN_IP_RST    = 32'd167772687;
  localparam logic [31:0] GW_IP_RST     = 32'd167772674;

  localparam int          TDATA_W       = 136;

  typedef enum logic [1:0] {
    ACT_IGNORE  = 2'd0,
    ACT_REPLY   = 2'd1,
    ACT_LEARNED = 2'd2
  } arpr_action_t;

  typedef enum logic [1:0] {
    REG_OWN_IP  = 2'd0,
    REG_GW_IP   = 2'd1,
    REG_OWN_MAC = 2'd2
  } arpr_reg_t;

  // lowest field last so the packed struct matches tdata order
  typedef struct packed {
    logic [47:0]  gw_mac;
    logic [31:0]  reply_ip;
    logic [47:0]  reply_mac;
    arpr_action_t action;
  } arpr_result_t;

endpackage

[hw/rtl/arpr_parse.sv]
// arpr_parse: byte position tracking, arp header capture and frame decision
// depends on arpr_pkg
module arpr_parse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_acc,
  input  logic [7:0]            frame_byte,
  input  logic                  last_byte,
  input  logic [31:0]           own_ip,
  input  logic [31:0]           gateway_ip,
  output logic                  res_valid,
  output arpr_pkg::arpr_result_t res
);
  import arpr_pkg::*;

  logic [5:0]  pos_r, pos_nxt;
  logic [15:0] ether_kind_r, ether_kind_nxt;
  logic [15:0] hw_kind_r, hw_kind_nxt;
  logic [15:0] proto_kind_r, proto_kind_nxt;
  logic [7:0]  hw_len_r, hw_len_nxt;
  logic [7:0]  proto_len_r, proto_len_nxt;
  logic [15:0] opcode_r, opcode_nxt;
  logic [47:0] sender_mac_r, sender_mac_nxt;
  logic [31:0] sender_ip_r, sender_ip_nxt;
  logic [31:0] target_ip_r, target_ip_nxt;
  logic [47:0] gw_mac_r, gw_mac_nxt;
  logic        frame_ok;

  // field capture by byte position, big-endian shift-in
  always_comb begin
    ether_kind_nxt = ether_kind_r;
    hw_kind_nxt    = hw_kind_r;
    proto_kind_nxt = proto_kind_r;
    hw_len_nxt     = hw_len_r;
    proto_len_nxt  = proto_len_r;
    opcode_nxt     = opcode_r;
    sender_mac_nxt = sender_mac_r;
    sender_ip_nxt  = sender_ip_r;
    target_ip_nxt  = target_ip_r;
    if (byte_acc) begin
      case (pos_r) inside
        6'd12, 6'd13:   ether_kind_nxt = {ether_kind_r[7:0], frame_byte};
        6'd14, 6'd15:   hw_kind_nxt    = {hw_kind_r[7:0], frame_byte};
        6'd16, 6'd17:   proto_kind_nxt = {proto_kind_r[7:0], frame_byte};
        6'd18:          hw_len_nxt     = frame_byte;
        6'd19:          proto_len_nxt  = frame_byte;
        6'd20, 6'd21:   opcode_nxt     = {opcode_r[7:0], frame_byte};
        [6'd22:6'd27]:  sender_mac_nxt = {sender_mac_r[39:0], frame_byte};
        [6'd28:6'd31]:  sender_ip_nxt  = {sender_ip_r[23:0], frame_byte};
        [6'd38:6'd41]:  target_ip_nxt  = {target_ip_r[23:0], frame_byte};
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (byte_acc) begin
      if (last_byte) begin
        pos_nxt = '0;
      end else if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + 6'd1;
      end
    end
  end

  assign frame_ok = (pos_r >= MIN_LAST_POS) && (ether_kind_nxt == ETHERTYPE_ARP) &&
                    (hw_kind_nxt == HTYPE_ETH) && (proto_kind_nxt == PTYPE_IPV4) &&
                    (hw_len_nxt == HLEN_MAC) && (proto_len_nxt == PLEN_IPV4);

  always_comb begin
    gw_mac_nxt    = gw_mac_r;
    res.action    = ACT_IGNORE;
    res.reply_mac = '0;
    res.reply_ip  = '0;
    if (byte_acc && last_byte && frame_ok) begin
      if (opcode_nxt == OP_REQUEST) begin
        if (sender_ip_nxt != own_ip && target_ip_nxt == own_ip) begin
          res.action    = ACT_REPLY;
          res.reply_mac = sender_mac_nxt;
          res.reply_ip  = sender_ip_nxt;
        end
      end else if (opcode_nxt == OP_REPLY) begin
        if (target_ip_nxt == own_ip && sender_ip_nxt == gateway_ip) begin
          res.action = ACT_LEARNED;
          gw_mac_nxt = sender_mac_nxt;
        end
      end
    end
    res.gw_mac = gw_mac_nxt;
  end

  assign res_valid = byte_acc && last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      gw_mac_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      gw_mac_r <= gw_mac_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ether_kind_r <= ether_kind_nxt;
    hw_kind_r    <= hw_kind_nxt;
    proto_kind_r <= proto_kind_nxt;
    hw_len_r     <= hw_len_nxt;
    proto_len_r  <= proto_len_nxt;
    opcode_r     <= opcode_nxt;
    sender_mac_r <= sender_mac_nxt;
    sender_ip_r  <= sender_ip_nxt;
    target_ip_r  <= target_ip_nxt;
  end

`ifndef SYNTHESIS
  a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_acc && last_byte) |=> (pos_r == '0))
    else $error("byte position not cleared after last byte");
  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_acc && !last_byte && pos_r == POS_MAX) |=> (pos_r == POS_MAX))
    else $error("byte position left saturation");
  a_short_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && pos_r < MIN_LAST_POS) |-> (res.action == ACT_IGNORE))
    else $error("short frame produced an action");
  a_gw_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.action != ACT_LEARNED) |=> $stable(gw_mac_r))
    else $error("gateway mac changed without a learn");
`endif

endmodule

[hw/rtl/arp_request_responder.sv]
// arp_request_responder: top level with config registers and result buffer
// depends on arpr_pkg and arpr_parse
//
// usage
//   in_*  : one received ethernet byte per request, in wire order; in_tdata[7:0]
//           is the byte and in_tlast marks the final byte of the frame
//   out_* : one result per frame, issued for the request that carries in_tlast
//   cfg_* : register writes (0 own ip, 1 gateway ip, 2 own mac), always ready;
//           own mac is accepted and left to the transmit side
//   result path: each result is registered in the output register, or in the skid register while the output stalls
//   throughput: one byte per cycle while in_tready is high, set by the single capture and compare stage
//   the result side holds two entries (output register plus skid register), so
//   bytes keep flowing while one finished result waits; in_tready drops only
//   when both entries are full
//   reset: byte position returns to zero, learned gateway mac clears to zero,
//   ip registers load their defaults, both result entries empty
//   a stalled out_tready holds out_tdata steady until taken
module arp_request_responder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] frame_byte
  input  logic                          in_tlast,   // last_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [1:0] action, [49:2] reply_mac, [81:50] reply_ip,
  // [129:82] learned_gateway_mac, [135:130] zero
  output logic [arpr_pkg::TDATA_W-1:0]  out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_addr,
  input  logic [47:0]                   cfg_data
);
  import arpr_pkg::*;

  logic [31:0]  own_ip_q_r, gw_ip_q_r;
  logic         byte_acc;
  logic         res_valid;
  arpr_result_t res;
  arpr_result_t main_r, skid_r;
  logic         main_v_r, skid_v_r;
  logic         main_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_q_r <= OWN_IP_RST;
      gw_ip_q_r  <= GW_IP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_OWN_IP: own_ip_q_r <= cfg_data[31:0];
        REG_GW_IP:  gw_ip_q_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !skid_v_r;
  assign byte_acc  = in_tvalid && in_tready;

  arpr_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_acc   (byte_acc),
    .frame_byte (in_tdata),
    .last_byte  (in_tlast),
    .own_ip     (own_ip_q_r),
    .gateway_ip (gw_ip_q_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign main_free = !main_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (main_free) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= res_valid;
      end else begin
        main_v_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_v_r) begin
        main_r <= skid_r;
        skid_r <= res;
      end else begin
        main_r <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = main_v_r;
  assign out_tdata  = {(TDATA_W - $bits(arpr_result_t))'(0), main_r};

`ifndef SYNTHESIS
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry held while output register empty");
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_acc && in_tlast && main_v_r && !out_tready) |=> skid_v_r)
    else $error("stalled result not kept in skid entry");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!main_v_r && !(byte_acc && in_tlast)) |=> !out_tvalid)
    else $error("result issued without a last byte");
  a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != 2'd3))
    else $error("undefined action code on output");
`endif

endmodule
